// ===== sv/tatc_pkg.sv =====
// shared types, constants and the segment table of the thermistor temperature reader
`default_nettype none
package tatc_pkg;

    localparam int SAMPLES_PER_RESULT_DEF = 10;

    localparam int ADC_W  = 10;
    localparam int SUM_W  = 16;
    localparam int TEMP_W = 7;
    localparam int RES_W  = 23;
    localparam int CEL_W  = 6;
    localparam int AVG_PROD_W = 22;

    // shared divider widths
    localparam int DIV_DW = 25;
    localparam int DIV_VW = 12;
    localparam int DIV_CW = $clog2(DIV_DW + 1);

    localparam logic [11:0]       VREF_MV   = 12'd3300;
    localparam logic [13:0]       R_SERIES  = 14'd10000;
    localparam logic [RES_W-1:0]  R_ZERO_C  = 23'd28017;
    localparam logic [TEMP_W-1:0] F_OFFSET  = 7'd32;
    localparam logic [4:0]        F_MUL     = 5'd18;
    localparam logic [11:0]       F_DIV     = 12'd10;
    localparam logic [ADC_W-1:0]  AVG_MAX   = 10'd1023;

    localparam int NUM_SEG = 8;

    typedef struct packed {
        logic [14:0] hi;
        logic [14:0] lo;
        logic [5:0]  base;
        logic [9:0]  step;
    } seg_t;

    localparam seg_t SEG_TAB [NUM_SEG] = '{
        '{hi: 15'd26825, lo: 15'd18560, base: 6'd1,  step: 10'd1000},
        '{hi: 15'd18560, lo: 15'd12690, base: 6'd10, step: 10'd700},
        '{hi: 15'd12690, lo: 15'd10953, base: 6'd20, step: 10'd600},
        '{hi: 15'd10953, lo: 15'd9576,  base: 6'd23, step: 10'd500},
        '{hi: 15'd9576,  lo: 15'd8160,  base: 6'd26, step: 10'd350},
        '{hi: 15'd8160,  lo: 15'd7578,  base: 6'd30, step: 10'd300},
        '{hi: 15'd7578,  lo: 15'd6357,  base: 6'd32, step: 10'd250},
        '{hi: 15'd6357,  lo: 15'd4828,  base: 6'd37, step: 10'd200}
    };

    typedef struct packed {
        logic [TEMP_W-1:0] temperature;
        logic [RES_W-1:0]  resistance_ohms;
        logic              in_range;
    } res_t;

endpackage
`default_nettype wire

// ===== sv/thermistor_adc_to_temperature_top.sv =====
// top level: sample accumulator, mode register, result output register
// a sample that does not close a group is accumulated, the next one can follow at once
// the sample that closes a group starts the conversion; m_tvalid rises once the result has
// passed average, resistance, table lookup and, in fahrenheit, the unit conversion
// s_tready stays low during the conversion; the result waits in its own output register
// rst_n is asynchronous: it clears the accumulator, count, held temperature, mode and m_tvalid
`default_nettype none
module thermistor_adc_to_temperature_top #(
    parameter int SAMPLES_PER_RESULT = tatc_pkg::SAMPLES_PER_RESULT_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic        cfg_wr_data,   // fahrenheit_mode
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,       // [9:0] adc_sample
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,       // [6:0] temperature, [29:7] resistance_ohms
    output logic             m_tuser        // in_range
);
    import tatc_pkg::*;

    localparam int CNT_W = $clog2(SAMPLES_PER_RESULT + 1);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SAMPLES_PER_RESULT - 1);

    logic              mode_reg;
    logic [SUM_W-1:0]  sum_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              m_tvalid_reg;
    logic [31:0]       m_tdata_reg;
    logic              m_tuser_reg;

    logic              s_xfer;
    logic [SUM_W-1:0]  sum_add;
    logic              core_start;
    logic              core_idle;
    logic              res_valid;
    logic              res_ready;
    res_t              res;

    assign s_tready   = core_idle;
    assign s_xfer     = s_tvalid && s_tready;
    assign sum_add    = sum_reg + {{(SUM_W-ADC_W){1'b0}}, s_tdata[ADC_W-1:0]};
    assign core_start = s_xfer && (cnt_reg == CNT_LAST);
    assign res_ready  = !m_tvalid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 1'b0;
            sum_reg  <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (cfg_wr_en)
                mode_reg <= cfg_wr_data;
            if (s_xfer)
            begin
                if (cnt_reg == CNT_LAST)
                begin
                    sum_reg <= '0;
                    cnt_reg <= '0;
                end
                else
                begin
                    sum_reg <= sum_add;
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
        end
    end

    tatc_core #(
        .SAMPLES_PER_RESULT (SAMPLES_PER_RESULT)
    ) u_core (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (core_start),
        .sum             (sum_add),
        .fahrenheit_mode (mode_reg),
        .idle            (core_idle),
        .res_valid       (res_valid),
        .res_ready       (res_ready),
        .res             (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if (res_valid && res_ready)
            m_tvalid_reg <= 1'b1;
        else if (m_tready)
            m_tvalid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            m_tdata_reg <= {2'b00, res.resistance_ohms, res.temperature};
            m_tuser_reg <= res.in_range;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // closing a group must stall the input side
    a_start_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        core_start |=> !s_tready)
        else $error("input still ready after a group closed");

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_LAST)
        else $error("sample count beyond group size");

    // a finished result waits until the output register frees up
    a_res_wait: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res))
        else $error("result lost while output register busy");

    a_no_input_busy: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !s_tready)
        else $error("input ready while result pending in core");

endmodule
`default_nettype wire

// ===== sv/tatc_div.sv =====
// iterative restoring divider, one quotient bit per cycle
`default_nettype none
module tatc_div (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [tatc_pkg::DIV_DW-1:0]   dividend,
    input  wire logic [tatc_pkg::DIV_VW-1:0]   divisor,
    output logic                               done,
    output logic [tatc_pkg::DIV_DW-1:0]        quotient
);
    import tatc_pkg::*;

    logic              busy_reg;
    logic [DIV_CW-1:0] cnt_reg;
    logic [DIV_DW-1:0] q_reg;
    logic [DIV_VW-1:0] rem_reg;
    logic [DIV_VW-1:0] divisor_reg;
    logic [DIV_VW:0]   shifted;
    logic [DIV_VW+1:0] diff;

    assign shifted  = {rem_reg, q_reg[DIV_DW-1]};
    assign diff     = {1'b0, shifted} - {2'b00, divisor_reg};
    assign done     = busy_reg && (cnt_reg == '0);
    assign quotient = q_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= DIV_CW'(DIV_DW);
        end
        else if (busy_reg)
        begin
            if (cnt_reg == '0)
                busy_reg <= 1'b0;
            else
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg       <= dividend;
            rem_reg     <= '0;
            divisor_reg <= divisor;
        end
        else if (busy_reg && (cnt_reg != '0))
        begin
            // remainder stays below the divisor, so the low bits hold it
            if (!diff[DIV_VW+1])
            begin
                rem_reg <= diff[DIV_VW-1:0];
                q_reg   <= {q_reg[DIV_DW-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted[DIV_VW-1:0];
                q_reg   <= {q_reg[DIV_DW-2:0], 1'b0};
            end
        end
    end

endmodule
`default_nettype wire

// ===== sv/tatc_core.sv =====
// sequencer that runs average, resistance, table lookup and unit conversion on one divider
`default_nettype none
module tatc_core #(
    parameter int SAMPLES_PER_RESULT = tatc_pkg::SAMPLES_PER_RESULT_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire logic [tatc_pkg::SUM_W-1:0]   sum,
    input  wire logic                         fahrenheit_mode,
    output logic                              idle,
    output logic                              res_valid,
    input  wire logic                         res_ready,
    output tatc_pkg::res_t                    res
);
    import tatc_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_AVG,
        S_PROD,
        S_RES,
        S_LOOK,
        S_SEG,
        S_CONV,
        S_FAHR,
        S_DONE
    } state_t;

    localparam logic [DIV_VW-1:0] N_DIV = DIV_VW'(SAMPLES_PER_RESULT);

    state_t                state_reg;
    logic [AVG_PROD_W-1:0] prod_reg;
    logic [RES_W-1:0]      r_reg;
    logic [CEL_W-1:0]      held_reg;
    logic [CEL_W-1:0]      base_reg;
    logic                  ok_reg;
    logic [TEMP_W-1:0]     temp_reg;

    logic              div_start;
    logic [DIV_DW-1:0] div_dividend;
    logic [DIV_VW-1:0] div_divisor;
    logic              div_done;
    logic [DIV_DW-1:0] div_quot;

    logic [11:0]       mv;
    logic [ADC_W-1:0]  avg;
    logic              seg_hit;
    logic [2:0]        seg_sel;
    seg_t              seg;

    assign mv  = prod_reg[AVG_PROD_W-1:10];
    assign avg = (div_quot[DIV_DW-1:ADC_W] != '0) ? AVG_MAX : div_quot[ADC_W-1:0];
    assign seg = SEG_TAB[seg_sel];

    // segments are disjoint, the first hit is the only one
    always_comb
    begin
        seg_hit = 1'b0;
        seg_sel = '0;
        for (int k = 0; k < NUM_SEG; k++)
        begin
            if (!seg_hit && (r_reg > {8'b0, SEG_TAB[k].lo}) && (r_reg <= {8'b0, SEG_TAB[k].hi}))
            begin
                seg_hit = 1'b1;
                seg_sel = k[2:0];
            end
        end
    end

    always_comb
    begin
        div_start    = 1'b0;
        div_dividend = '0;
        div_divisor  = N_DIV;
        unique case (state_reg)
            S_IDLE:
            begin
                div_start    = start;
                div_dividend = DIV_DW'(sum);
                div_divisor  = N_DIV;
            end
            S_PROD:
            begin
                div_start    = 1'b1;
                div_dividend = {13'b0, mv} * {11'b0, R_SERIES};
                div_divisor  = VREF_MV - mv;
            end
            S_LOOK:
            begin
                div_start    = seg_hit && (r_reg != R_ZERO_C);
                div_dividend = DIV_DW'(seg.hi - r_reg[14:0]);
                div_divisor  = DIV_VW'(seg.step);
            end
            S_CONV:
            begin
                div_start    = fahrenheit_mode;
                div_dividend = {19'b0, held_reg} * {20'b0, F_MUL};
                div_divisor  = F_DIV;
            end
            S_AVG, S_RES, S_SEG, S_FAHR, S_DONE:
            begin
                div_start = 1'b0;
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    tatc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quot)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            held_reg  <= '0;
            ok_reg    <= 1'b0;
            prod_reg  <= '0;
            r_reg     <= '0;
            base_reg  <= '0;
            temp_reg  <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                        state_reg <= S_AVG;
                end
                S_AVG:
                begin
                    if (div_done)
                    begin
                        prod_reg  <= {12'b0, avg} * {10'b0, VREF_MV};
                        state_reg <= S_PROD;
                    end
                end
                S_PROD:
                begin
                    state_reg <= S_RES;
                end
                S_RES:
                begin
                    if (div_done)
                    begin
                        r_reg     <= div_quot[RES_W-1:0];
                        state_reg <= S_LOOK;
                    end
                end
                S_LOOK:
                begin
                    if (r_reg == R_ZERO_C)
                    begin
                        held_reg  <= '0;
                        ok_reg    <= 1'b1;
                        state_reg <= S_CONV;
                    end
                    else if (seg_hit)
                    begin
                        base_reg  <= seg.base;
                        state_reg <= S_SEG;
                    end
                    else
                    begin
                        // out of the table: keep the last temperature
                        ok_reg    <= 1'b0;
                        state_reg <= S_CONV;
                    end
                end
                S_SEG:
                begin
                    if (div_done)
                    begin
                        held_reg  <= base_reg + div_quot[CEL_W-1:0];
                        ok_reg    <= 1'b1;
                        state_reg <= S_CONV;
                    end
                end
                S_CONV:
                begin
                    if (fahrenheit_mode)
                        state_reg <= S_FAHR;
                    else
                    begin
                        temp_reg  <= {1'b0, held_reg};
                        state_reg <= S_DONE;
                    end
                end
                S_FAHR:
                begin
                    if (div_done)
                    begin
                        temp_reg  <= F_OFFSET + div_quot[TEMP_W-1:0];
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (res_ready)
                        state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign idle                = (state_reg == S_IDLE);
    assign res_valid           = (state_reg == S_DONE);
    assign res.temperature     = temp_reg;
    assign res.resistance_ohms = r_reg;
    assign res.in_range        = ok_reg;

endmodule
`default_nettype wire
